// ===== hdl/spmq_pkg.sv =====
// spmq_pkg: constants, status and action codes, controller states and the
// command/status structs shared by the strict-priority multi-queue modules.
// no dependencies
`default_nettype none

package spmq_pkg;

  // sizing of the queue block
  localparam int LEVELS      = 5;
  localparam int QUEUE_DEPTH = 16;
  localparam int ITEM_WIDTH  = 16;

  // fixed field widths of the stream items
  localparam int ID_W  = 16;
  localparam int LVL_W = 3;
  localparam int ST_W  = 3;

  // derived widths
  localparam int QIDX_W = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int SUM_W  = CNT_W + 1;
  localparam int ADDR_W = $clog2(LEVELS * QUEUE_DEPTH);

  // stream packing
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;
  localparam int OUT_PAD_W  = OUT_DATA_W - ID_W - LVL_W;
  localparam int IN_PAD_W   = IN_DATA_W - LVL_W - ID_W;

  typedef enum logic [ST_W-1:0] {
    ST_ADDED     = 3'd0,
    ST_BAD_LEVEL = 3'd1,
    ST_FULL      = 3'd2,
    ST_PASSED    = 3'd3,
    ST_EMPTY     = 3'd4
  } status_t;

  typedef enum logic [0:0] {
    ACT_ENQ = 1'b0,
    ACT_DEQ = 1'b1
  } action_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_OUT
  } ctrl_state_t;

  // controller -> datapath
  typedef struct packed {
    logic load;         // capture the accepted item
    logic enq_write;    // append to the addressed queue
    logic deq_pop;      // read and remove the selected head
    logic take_result;  // register status and level
    logic take_read;    // register the item read from storage
  } ctl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_deq;
    logic enq_ok;
    logic any_waiting;
  } ctl_stat_t;

endpackage

`default_nettype wire

// ===== hdl/strict_priority_multi_queue.sv =====
// strict_priority_multi_queue: top level, joins the controller and datapath
// and packs the stream items. depends on spmq_pkg, spmq_ctrl, spmq_dp
`default_nettype none

// Five bounded FIFO queues, one per priority level 1 (most urgent) to 5,
// each 16 items deep. An input item either enqueues an id at a level or
// dequeues the head of the lowest-numbered non-empty queue; every input
// item yields exactly one result item with a status code (added, invalid
// level, queue full, item passed, nothing waiting), the id removed and its
// level (both zero unless an item was passed). The block handles one item
// at a time: an enqueue or a failed dequeue passes through the execute and
// output states before the next accept; a successful dequeue also passes
// through a read state between them, for the registered read port of the item
// storage. Any wait on m_tready holds the block in its output state. Queue
// contents are not cleared by reset; head pointers and fill counts are.
module strict_priority_multi_queue
  import spmq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  // input items
  input  wire logic                  s_tvalid,
  output logic                       s_tready,
  input  wire logic [IN_DATA_W-1:0]  s_tdata,   // level[2:0], item_id[18:3], zero pad
  input  wire logic                  s_tuser,   // action: 0 enqueue, 1 dequeue
  // result items
  output logic                       m_tvalid,
  input  wire logic                  m_tready,
  output logic [OUT_DATA_W-1:0]      m_tdata,   // out_item[15:0], out_level[18:16], zero pad
  output logic [ST_W-1:0]            m_tuser    // status
);

  ctl_cmd_t         cmd;
  ctl_stat_t        stat;
  status_t          res_status;
  logic [ID_W-1:0]  res_item;
  logic [LVL_W-1:0] res_level;
  action_t          in_action;

  // unpack the input item
  assign in_action = action_t'(s_tuser);

  spmq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spmq_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .action     (in_action),
    .level      (s_tdata[LVL_W-1:0]),
    .item_id    (s_tdata[LVL_W+ID_W-1:LVL_W]),
    .cmd        (cmd),
    .stat       (stat),
    .res_status (res_status),
    .res_item   (res_item),
    .res_level  (res_level)
  );

  // pack the result item; the result registers hold while m_tvalid is up
  assign m_tdata = {{OUT_PAD_W{1'b0}}, res_level, res_item};
  assign m_tuser = res_status;

`ifndef SYNTHESIS
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input taken while a result is pending");
  a_pass_has_level: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_PASSED) |-> m_tdata[ID_W+LVL_W-1:ID_W] != '0)
    else $error("passed item without a level");
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser != ST_PASSED) |-> m_tdata == '0)
    else $error("nonzero item or level on a result without a passed item");
`endif

endmodule

`default_nettype wire

// ===== hdl/spmq_dp.sv =====
// spmq_dp: datapath of the multi-queue: item storage, head pointers, fill
// counts, priority encoder and result registers.
// depends on spmq_pkg
`default_nettype none

module spmq_dp
  import spmq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire action_t               action,
  input  wire logic [LVL_W-1:0]      level,
  input  wire logic [ID_W-1:0]       item_id,
  input  wire ctl_cmd_t              cmd,
  output ctl_stat_t                  stat,
  output status_t                    res_status,
  output logic [ID_W-1:0]            res_item,
  output logic [LVL_W-1:0]           res_level
);

  logic [ITEM_WIDTH-1:0] mem [LEVELS*QUEUE_DEPTH];
  logic [ITEM_WIDTH-1:0] rd_data;

  logic [PTR_W-1:0] head [LEVELS];
  logic [CNT_W-1:0] fill [LEVELS];

  action_t          in_action;
  logic [LVL_W-1:0] in_level;
  logic [ID_W-1:0]  in_item;

  logic [QIDX_W-1:0] enq_q;
  logic [QIDX_W-1:0] deq_q;
  logic              level_ok;
  logic              queue_full;
  logic              any_waiting;
  logic [SUM_W-1:0]  tail_sum;
  logic [PTR_W-1:0]  tail;
  logic [PTR_W-1:0]  head_next;
  logic [ADDR_W-1:0] wr_addr;
  logic [ADDR_W-1:0] rd_addr;
  status_t           result;

  always_comb begin
    enq_q      = QIDX_W'(in_level - LVL_W'(1));
    level_ok   = (in_level != '0) && (32'(in_level) <= 32'(LEVELS));
    queue_full = (fill[enq_q] == CNT_W'(QUEUE_DEPTH));

    // lowest-numbered queue holding anything wins
    deq_q       = '0;
    any_waiting = 1'b0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (fill[i] != '0) begin
        deq_q       = QIDX_W'(i);
        any_waiting = 1'b1;
      end
    end

    // tail = (head + fill) mod depth, the sum stays below twice the depth
    tail_sum = SUM_W'(head[enq_q]) + SUM_W'(fill[enq_q]);
    if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
      tail = PTR_W'(tail_sum - SUM_W'(QUEUE_DEPTH));
    end else begin
      tail = PTR_W'(tail_sum);
    end

    if (head[deq_q] == PTR_W'(QUEUE_DEPTH - 1)) begin
      head_next = '0;
    end else begin
      head_next = head[deq_q] + PTR_W'(1);
    end

    wr_addr = ADDR_W'(enq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(tail);
    rd_addr = ADDR_W'(deq_q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(head[deq_q]);

    if (in_action == ACT_DEQ) begin
      result = any_waiting ? ST_PASSED : ST_EMPTY;
    end else if (!level_ok) begin
      result = ST_BAD_LEVEL;
    end else if (queue_full) begin
      result = ST_FULL;
    end else begin
      result = ST_ADDED;
    end

    stat.is_deq      = (in_action == ACT_DEQ);
    stat.enq_ok      = level_ok && !queue_full;
    stat.any_waiting = any_waiting;
  end

  // item storage, one write or one registered read a cycle
  always_ff @(posedge clk) begin
    if (cmd.enq_write) begin
      mem[wr_addr] <= ITEM_WIDTH'(in_item);
    end
    if (cmd.deq_pop) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_action <= action;
      in_level  <= level;
      in_item   <= item_id;
    end
    if (cmd.take_result) begin
      res_status <= result;
      res_item   <= '0;
      if ((in_action == ACT_DEQ) && any_waiting) begin
        res_level <= LVL_W'(deq_q) + LVL_W'(1);
      end else begin
        res_level <= '0;
      end
    end
    if (cmd.take_read) begin
      res_item <= ID_W'(rd_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i] <= '0;
        fill[i] <= '0;
      end
    end else if (cmd.enq_write) begin
      fill[enq_q] <= fill[enq_q] + CNT_W'(1);
    end else if (cmd.deq_pop) begin
      fill[deq_q] <= fill[deq_q] - CNT_W'(1);
      head[deq_q] <= head_next;
    end
  end

`ifndef SYNTHESIS
  for (genvar g = 0; g < LEVELS; g++) begin : g_chk
    a_fill_bound: assert property (@(posedge clk) disable iff (rst)
      fill[g] <= CNT_W'(QUEUE_DEPTH))
      else $error("queue fill count above depth");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
      cmd.deq_pop && (deq_q == QIDX_W'(g)) |-> fill[g] != '0)
      else $error("pop from an empty queue");
  end
`endif

endmodule

`default_nettype wire

// ===== hdl/spmq_ctrl.sv =====
// spmq_ctrl: sequencing state machine of the multi-queue, one item at a time.
// depends on spmq_pkg
`default_nettype none

module spmq_ctrl
  import spmq_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      s_tvalid,
  output logic           s_tready,
  output logic           m_tvalid,
  input  wire logic      m_tready,
  input  wire ctl_stat_t stat,
  output ctl_cmd_t       cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    m_tvalid   = 1'b0;
    unique case (state)
      S_IDLE: begin
        // no item is taken while reset is held
        s_tready = !rst;
        if (s_tvalid && !rst) begin
          cmd.load   = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.take_result = 1'b1;
        if (stat.is_deq) begin
          if (stat.any_waiting) begin
            cmd.deq_pop = 1'b1;
            state_next  = S_READ;
          end else begin
            state_next = S_OUT;
          end
        end else begin
          cmd.enq_write = stat.enq_ok;
          state_next    = S_OUT;
        end
      end
      S_READ: begin
        cmd.take_read = 1'b1;
        state_next    = S_OUT;
      end
      S_OUT: begin
        m_tvalid = 1'b1;
        if (m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ===== test/strict_priority_multi_queue_test.sv =====
// strict_priority_multi_queue_test: self-checking bench for the five-level
// strict-priority queue block, with a directed table then random traffic.
// depends on spmq_pkg and strict_priority_multi_queue
module strict_priority_multi_queue_test;
  import spmq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    status_t               status;
    logic [ID_W-1:0]       item;
    logic [LVL_W-1:0]      lvl;
  } outcome_t;

  // one row of the directed table
  typedef struct {
    action_t               act;
    logic [LVL_W-1:0]      lvl;
    logic [ID_W-1:0]       id;
    bit                    typed;
    status_t               typed_status;
  } dir_row_t;

  typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_FLOOD} phase_t;

  localparam int RANDOM_ITEMS = 2000;
  localparam int IDLE_PCT     = 20;
  localparam int TAIL_CYCLES  = 10;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_DATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_tdata;
  logic [ST_W-1:0]        m_tuser;

  // shadow of the queue block
  logic [ITEM_WIDTH-1:0]  shadow_store [LEVELS][QUEUE_DEPTH];
  int                     shadow_head [LEVELS];
  int                     shadow_fill [LEVELS];

  outcome_t               awaited_outcomes[$];
  dir_row_t               directed_rows[$];
  int                     err_count;
  int                     items_in;
  int                     directed_in;
  int                     status_tally [5];
  logic                   steady;

  strict_priority_multi_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // a stretch in the middle of the run with no idling on either side
  assign steady = (items_in >= 900) && (items_in < 1200);

  // apply one item to the shadow queues and return the outcome
  function automatic outcome_t queue_step(action_t act, logic [LVL_W-1:0] lvl,
                                          logic [ID_W-1:0] id);
    outcome_t r;
    int q;
    int tail;
    bit found;
    r = '{ST_EMPTY, '0, '0};
    found = 1'b0;
    if (act == ACT_ENQ) begin
      if (lvl < 1 || lvl > LEVELS) begin
        r.status = ST_BAD_LEVEL;
      end else begin
        q = lvl - 1;
        if (shadow_fill[q] >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          tail = (shadow_head[q] + shadow_fill[q]) % QUEUE_DEPTH;
          shadow_store[q][tail] = id[ITEM_WIDTH-1:0];
          shadow_fill[q]++;
          r.status = ST_ADDED;
        end
      end
    end else begin
      // lowest-numbered non-empty queue wins
      for (q = 0; q < LEVELS; q++) begin
        if (!found && shadow_fill[q] != 0) begin
          found = 1'b1;
          r.status = ST_PASSED;
          r.item = ID_W'(shadow_store[q][shadow_head[q]]);
          r.lvl = LVL_W'(q + 1);
          shadow_head[q] = (shadow_head[q] + 1) % QUEUE_DEPTH;
          shadow_fill[q]--;
        end
      end
    end
    return r;
  endfunction

  // offer one item, wait for the handshake, then record what should come back
  task automatic send_item(action_t act, logic [LVL_W-1:0] lvl, logic [ID_W-1:0] id,
                           bit typed, status_t typed_status);
    outcome_t predicted;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {{IN_PAD_W{1'b0}}, id, lvl};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = queue_step(act, lvl, id);
    // rows with a hand-written outcome carry no item and no level
    if (typed) predicted = '{typed_status, '0, '0};
    awaited_outcomes.push_back(predicted);
    items_in++;
  endtask

  task automatic add_row(action_t act, int lvl, int id, bit typed, status_t st);
    dir_row_t row;
    row.act = act;
    row.lvl = LVL_W'(lvl);
    row.id = ID_W'(id);
    row.typed = typed;
    row.typed_status = st;
    directed_rows.push_back(row);
  endtask

  // result side: check each taken item, then pick the next ready
  always @(posedge clk) begin : result_check
    outcome_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (m_tuser < 5) status_tally[m_tuser]++;
        if (awaited_outcomes.size() == 0) begin
          $display("%0t: result with nothing awaited, status %0d item %h level %0d",
                   $realtime, m_tuser, m_tdata[ID_W-1:0], m_tdata[ID_W +: LVL_W]);
          err_count++;
        end else begin
          want = awaited_outcomes.pop_front();
          if (m_tuser !== want.status) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $realtime, want.status, m_tuser);
            err_count++;
          end
          if (m_tdata[ID_W-1:0] !== want.item) begin
            $display("%0t: item mismatch, expected %h actual %h",
                     $realtime, want.item, m_tdata[ID_W-1:0]);
            err_count++;
          end
          if (m_tdata[ID_W +: LVL_W] !== want.lvl) begin
            $display("%0t: level mismatch, expected %0d actual %0d",
                     $realtime, want.lvl, m_tdata[ID_W +: LVL_W]);
            err_count++;
          end
        end
      end
      m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  initial begin : stimulus
    phase_t           phase;
    int               phase_len;
    int               flood_level;
    int               random_sent;
    int               k;
    int               roll;
    action_t          act;
    logic [LVL_W-1:0] lvl;
    logic [ID_W-1:0]  id;

    // empty block, invalid levels, at least one item per level, ignored fields on dequeue
    add_row(ACT_DEQ, 0, 16'h0000, 1'b1, ST_EMPTY);
    add_row(ACT_ENQ, 0, 16'h1234, 1'b1, ST_BAD_LEVEL);
    add_row(ACT_ENQ, 6, 16'hFFFF, 1'b1, ST_BAD_LEVEL);
    add_row(ACT_ENQ, 7, 16'h0000, 1'b1, ST_BAD_LEVEL);
    add_row(ACT_ENQ, 5, 16'hFFFF, 1'b1, ST_ADDED);
    add_row(ACT_ENQ, 4, 16'h8001, 1'b0, ST_ADDED);
    add_row(ACT_ENQ, 3, 16'hA5A5, 1'b0, ST_ADDED);
    add_row(ACT_ENQ, 2, 16'h5A5A, 1'b0, ST_ADDED);
    add_row(ACT_ENQ, 1, 16'h0000, 1'b0, ST_ADDED);
    add_row(ACT_ENQ, 1, 16'h0001, 1'b0, ST_ADDED);
    add_row(ACT_DEQ, 7, 16'hFFFF, 1'b0, ST_PASSED);
    add_row(ACT_DEQ, 0, 16'h0000, 1'b0, ST_PASSED);
    add_row(ACT_ENQ, 2, 16'h7FFF, 1'b0, ST_ADDED);
    add_row(ACT_DEQ, 2, 16'h0000, 1'b0, ST_PASSED);
    add_row(ACT_DEQ, 0, 16'h0000, 1'b0, ST_PASSED);
    add_row(ACT_DEQ, 0, 16'h0000, 1'b0, ST_PASSED);
    add_row(ACT_DEQ, 0, 16'h0000, 1'b0, ST_PASSED);
    add_row(ACT_DEQ, 0, 16'h0000, 1'b0, ST_PASSED);
    add_row(ACT_DEQ, 5, 16'h0001, 1'b1, ST_EMPTY);
    add_row(ACT_ENQ, 5, 16'h0000, 1'b0, ST_ADDED);
    add_row(ACT_DEQ, 0, 16'h0000, 1'b0, ST_PASSED);

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i])
      send_item(directed_rows[i].act, directed_rows[i].lvl, directed_rows[i].id,
                directed_rows[i].typed, directed_rows[i].typed_status);
    directed_in = items_in;

    // random traffic in phases: filling, draining, mixed, and floods of one level
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      phase = phase_t'($urandom_range(3));
      phase_len = $urandom_range(10, 60);
      flood_level = $urandom_range(1, LEVELS);
      for (k = 0; k < phase_len; k++) begin
        roll = $urandom_range(99);
        case (phase)
          PH_FILL:  act = (roll < 85) ? ACT_ENQ : ACT_DEQ;
          PH_DRAIN: act = (roll < 85) ? ACT_DEQ : ACT_ENQ;
          PH_MIXED: act = (roll < 50) ? ACT_ENQ : ACT_DEQ;
          default:  act = (roll < 95) ? ACT_ENQ : ACT_DEQ;
        endcase
        id = ID_W'($urandom_range(16'hFFFF));
        if (act == ACT_DEQ) begin
          lvl = LVL_W'($urandom_range(7));
        end else if (phase == PH_FLOOD) begin
          lvl = LVL_W'(flood_level);
        end else if ($urandom_range(99) < 90) begin
          lvl = LVL_W'($urandom_range(1, LEVELS));
        end else begin
          // invalid levels: zero and above the top level
          roll = $urandom_range(2);
          lvl = (roll == 0) ? '0 : LVL_W'(LEVELS + roll);
        end
        send_item(act, lvl, id, 1'b0, ST_ADDED);
        random_sent++;
      end
    end
    s_tvalid <= 1'b0;

    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d items in: %0d from the directed table, %0d random",
             items_in, directed_in, items_in - directed_in);
    $display("outcomes: %0d added, %0d bad level, %0d full, %0d passed, %0d nothing waiting",
             status_tally[ST_ADDED], status_tally[ST_BAD_LEVEL], status_tally[ST_FULL],
             status_tally[ST_PASSED], status_tally[ST_EMPTY]);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // hang guard
  initial begin
    #20_000_000;
    $display("timeout with %0d results still awaited", awaited_outcomes.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
